@@ hw/rtl/spq_pkg.sv @@
// Shared constants, codes and types for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic exec;
  } spq_cmd_t;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
// Handshake controller: accepts beats and tracks the output register.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output spq_cmd_t cmd
);

  typedef enum logic {
    S_OUT_EMPTY,
    S_OUT_HOLD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready  = (state_r == S_OUT_EMPTY) || out_tready;
  assign out_tvalid = (state_r == S_OUT_HOLD);
  assign cmd.exec   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_OUT_EMPTY: begin
        if (cmd.exec) state_nxt = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (cmd.exec) state_nxt = S_OUT_HOLD;
        else if (out_tready) state_nxt = S_OUT_EMPTY;
      end
      default: state_nxt = S_OUT_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_OUT_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/spq_dp.sv @@
// Datapath: sorted shift-register entry cells, entry count and result register.
module spq_dp
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  spq_cmd_t                cmd,
  input  logic [CAP_W-1:0]        capacity,
  input  logic                    func,
  input  logic signed [VAL_W-1:0] item_value,
  input  logic signed [PRI_W-1:0] item_priority,
  output logic [STAT_W-1:0]       status,
  output logic signed [VAL_W-1:0] out_value,
  output logic signed [PRI_W-1:0] out_priority,
  output logic [OCC_W-1:0]        occupancy
);

  logic signed [VAL_W-1:0] val_r   [DEPTH];
  logic signed [PRI_W-1:0] pri_r   [DEPTH];
  logic signed [VAL_W-1:0] val_nxt [DEPTH];
  logic signed [PRI_W-1:0] pri_nxt [DEPTH];
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        cap_eff;
  logic [DEPTH-1:0]        ge;
  logic                    is_full;
  logic                    is_empty;

  logic [STAT_W-1:0]       status_r,   status_nxt;
  logic signed [VAL_W-1:0] value_r,    value_nxt;
  logic signed [PRI_W-1:0] priority_r, priority_nxt;
  logic [OCC_W-1:0]        occ_r;

  always_comb begin
    if (int'(capacity) > DEPTH) cap_eff = CNT_W'(DEPTH);
    else cap_eff = CNT_W'(capacity);
    is_full  = (count_r >= cap_eff);
    is_empty = (count_r == '0);

    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (pri_r[i] >= item_priority);
    end

    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt    = count_r;
    status_nxt   = ST_DONE;
    value_nxt    = '0;
    priority_nxt = '0;

    if (func == FUNC_ENQ) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        if (!ge[0]) begin
          val_nxt[0] = item_value;
          pri_nxt[0] = item_priority;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!ge[i]) begin
            if (ge[i-1]) begin
              val_nxt[i] = item_value;
              pri_nxt[i] = item_priority;
            end else begin
              val_nxt[i] = val_r[i-1];
              pri_nxt[i] = pri_r[i-1];
            end
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        value_nxt    = val_r[0];
        priority_nxt = pri_r[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          val_nxt[i] = val_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
      status_r   <= status_nxt;
      value_r    <= value_nxt;
      priority_r <= priority_nxt;
      occ_r      <= OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign status       = status_r;
  assign out_value    = value_r;
  assign out_priority = priority_r;
  assign occupancy    = occ_r;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: ports, capacity register and wiring.
//
// Channel  Direction  Beat contents
// in_      slave      tuser: func; tdata: item_value, item_priority
// out_     master     tuser: status; tdata: out_value, out_priority, occupancy
// cfg_     APB slave  capacity register at byte address 0
//
// One input beat is accepted per cycle; its result beat is offered the cycle after.
// The figure is set by the entry cells, which compare and shift combinationally.
// A new beat is taken while a result is held whenever that result leaves in the
// same cycle. Reset empties the queue at once, with no clearing pass.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,    // item_value[31:0], item_priority[47:32]
  input  logic [0:0]        in_tuser,    // func[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,   // out_value[31:0], out_priority[47:32],
                                         // occupancy[52:48], zero[55:53]
  output logic [1:0]        out_tuser,   // status[1:0]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  spq_cmd_t                cmd;
  logic [CAP_W-1:0]        capacity_r;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] out_value;
  logic signed [PRI_W-1:0] out_priority;
  logic [OCC_W-1:0]        occupancy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_CAPACITY)) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .capacity      (capacity_r),
    .func          (in_tuser[0]),
    .item_value    (in_tdata[31:0]),
    .item_priority (in_tdata[47:32]),
    .status        (status),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .occupancy     (occupancy)
  );

  assign out_tdata = {3'b000, occupancy, out_priority, out_value};
  assign out_tuser = status;

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// Self-checking testbench for the sorted priority queue, with its own queue predictor.
module sorted_priority_queue_tb
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 58;
  localparam int DRAIN_WAIT  = 4;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [2:0]        pad;
    logic [OCC_W-1:0]  occupancy;
    logic [PRI_W-1:0]  prio;
    logic [VAL_W-1:0]  value;
  } queue_result_t;

  class queue_scoreboard;
    logic [VAL_W-1:0] entry_value [DEPTH];
    logic [PRI_W-1:0] entry_prio [DEPTH];
    int unsigned      entry_count;
    logic [CAP_W-1:0] capacity;
    queue_result_t    expected_results [$];
    int               mismatches;

    function new();
      entry_count = 0;
      capacity    = CAP_RESET;
      mismatches  = 0;
    endfunction

    function void set_capacity(logic [DATA_W-1:0] wdata);
      capacity = wdata[CAP_W-1:0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_input(logic func, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
      queue_result_t res;
      int unsigned   limit;
      int unsigned   pos;
      int unsigned   i;
      res   = '0;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      if (func == FUNC_ENQ) begin
        if (entry_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_DONE;
          pos = 0;
          while (pos < entry_count && $signed(entry_prio[pos]) >= $signed(pri)) pos++;
          for (i = entry_count; i > pos; i--) begin
            entry_value[i] = entry_value[i-1];
            entry_prio[i]  = entry_prio[i-1];
          end
          entry_value[pos] = val;
          entry_prio[pos]  = pri;
          entry_count++;
        end
      end else begin
        if (entry_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_DONE;
          res.value  = entry_value[0];
          res.prio   = entry_prio[0];
          for (i = 1; i < entry_count; i++) begin
            entry_value[i-1] = entry_value[i];
            entry_prio[i-1]  = entry_prio[i];
          end
          entry_count--;
        end
      end
      res.occupancy = entry_count[OCC_W-1:0];
      expected_results.push_back(res);
    endfunction

    function void check(logic [STAT_W-1:0] st, logic [55:0] data);
      queue_result_t got;
      queue_result_t exp;
      got = {st, data};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: st=%0d data=%h",
                   $realtime, st, data);
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status || got.value !== exp.value || got.prio !== exp.prio ||
          got.occupancy !== exp.occupancy || got.pad !== exp.pad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: expected st=%0d val=%h pri=%h occ=%0d pad=%h, ",
                    "got st=%0d val=%h pri=%h occ=%0d pad=%h"},
                   $realtime, exp.status, exp.value, exp.prio, exp.occupancy, exp.pad,
                   got.status, got.value, got.prio, got.occupancy, got.pad);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;   // item_value[31:0], item_priority[47:32]
  logic [0:0]        in_tuser;   // func[0]
  logic              out_tvalid;
  logic              out_tready;
  logic [55:0]       out_tdata;  // out_value[31:0], out_priority[47:32],
                                 // occupancy[52:48], zero[55:53]
  logic [1:0]        out_tuser;  // status[1:0]
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  queue_scoreboard sb;
  bit              no_idle;
  bit              hold_req;

  sorted_priority_queue dut (.*);

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [PRI_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PRI_W'($urandom_range(0, 6) - 3);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return PRI_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r == 2) return 32'hffffffff;
    if (r == 3) return 32'h00000000;
    return $urandom;
  endfunction

  task automatic send_item(logic func, logic [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {pri, val};
    do @(posedge clk); while (!in_tready);
    sb.note_input(func, val, pri);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [DATA_W-1:0] wdata;
    wdata = ($urandom & ~DATA_W'(32'h1f)) | DATA_W'(cap);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * int'(REG_CAPACITY));
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_capacity(wdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  initial begin
    int run;
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check(out_tuser, out_tdata);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_caps [7];
    int               enq_bias;
    sb          = new();
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    phase_caps  = '{5'd16, 5'd31, 5'd1, 5'd7, 5'd0, 5'd17, 5'd16};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(FUNC_DEQ, 32'h0, 16'h0);
    send_item(FUNC_ENQ, 32'h7fffffff, 16'h8000);
    send_item(FUNC_ENQ, 32'h80000000, 16'h7fff);
    send_item(FUNC_ENQ, 32'h00000000, 16'h0000);
    send_item(FUNC_ENQ, 32'h00000001, 16'h0000);
    send_item(FUNC_ENQ, 32'hffffffff, 16'h0000);
    send_item(FUNC_ENQ, 32'h55aa55aa, 16'hffff);
    repeat (7) send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));

    wait_drained();
    write_capacity(5'd2);
    repeat (3) send_item(FUNC_ENQ, $urandom, 16'h0005);
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));

    wait_drained();
    write_capacity(5'd0);
    send_item(FUNC_ENQ, $urandom, 16'h0001);
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));

    wait_drained();
    write_capacity(5'd31);
    repeat (3) send_item(FUNC_ENQ, $urandom, 16'hfffe);

    wait_drained();
    write_capacity(5'd1);
    send_item(FUNC_ENQ, $urandom, 16'h7fff);
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));
    send_item(FUNC_ENQ, $urandom, 16'h7fff);
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));
    send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));
    send_item(FUNC_ENQ, $urandom, 16'h8000);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_capacity((p == 6) ? CAP_W'($urandom_range(0, 31)) : phase_caps[p]);
      enq_bias = (p == 1) ? 85 : $urandom_range(25, 80);
      no_idle  = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < enq_bias)
          send_item(FUNC_ENQ, pick_value(), pick_prio());
        else
          send_item(FUNC_DEQ, $urandom, PRI_W'($urandom));
      end
    end
    no_idle = 1'b0;

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dp.sv
hw/rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
